// ----- rtl/core/dmps_pkg.sv -----
// Shared constants, codes and types of the dual motor power sequencer.
package dmps_pkg;

  // Fixed field widths
  localparam int FUNC_W    = 3;
  localparam int VALUE_W   = 16;
  localparam int PWR_W     = 7;
  localparam int PHASE_W   = 2;
  localparam int STEP_W    = 4;
  localparam int DUR_W     = 16;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  // Block constants
  localparam int SEQ_STEPS  = 8;
  localparam int TIME_WIDTH = 32;
  localparam logic [PWR_W-1:0] FULL_POWER = 7'd100;
  localparam logic [DUR_W-1:0] RAMP_INTERVAL_RST = 16'd50;
  localparam logic [DUR_W-1:0] HOLD_TIME_RST     = 16'd3000;

  // Command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Input function codes
  localparam logic [FUNC_W-1:0] FN_TICK      = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SET_BOTH  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_START_RMP = 3'd2;
  localparam logic [FUNC_W-1:0] FN_START_SEQ = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SET_A     = 3'd4;
  localparam logic [FUNC_W-1:0] FN_SET_B     = 3'd5;

  // Classified operations carried through the queue
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NONE      = 3'd0;
  localparam logic [OP_W-1:0] OP_TICK      = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_BOTH  = 3'd2;
  localparam logic [OP_W-1:0] OP_START_RMP = 3'd3;
  localparam logic [OP_W-1:0] OP_START_SEQ = 3'd4;
  localparam logic [OP_W-1:0] OP_SET_A     = 3'd5;
  localparam logic [OP_W-1:0] OP_SET_B     = 3'd6;

  // Ramp test phases
  localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
  localparam logic [PHASE_W-1:0] PH_UP   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_HOLD = 2'd2;
  localparam logic [PHASE_W-1:0] PH_DOWN = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_POWERS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_TIMES_LO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_TIMES_HI  = 3'd4;

  // Queue entry: classified operation and clamped power
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [PWR_W-1:0] power;
  } cmd_t;

  // Configuration write bundle
  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

endpackage

// ----- rtl/core/dmps_if.sv -----
// Valid/ready channel interfaces for commands and results.
interface dmps_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [dmps_pkg::FUNC_W-1:0]   func;
  logic signed [dmps_pkg::VALUE_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface dmps_res_if;
  logic                         valid;
  logic                         ready;
  logic [dmps_pkg::PWR_W-1:0]   drive_a;
  logic [dmps_pkg::PWR_W-1:0]   drive_b;
  logic [dmps_pkg::PHASE_W-1:0] ramp_phase;
  logic                         sequence_running;
  logic [dmps_pkg::STEP_W-1:0]  sequence_step;

  modport source (output valid, output drive_a, output drive_b, output ramp_phase,
                  output sequence_running, output sequence_step, input ready);
  modport sink   (input valid, input drive_a, input drive_b, input ramp_phase,
                  input sequence_running, input sequence_step, output ready);
endinterface

// ----- rtl/core/dmps_front.sv -----
// Front end: accepts command transactions, classifies them and queues them.
module dmps_front (
  input  logic            clk,
  input  logic            rst,
  dmps_cmd_if.sink        cmd,
  output logic            q_valid,
  output dmps_pkg::cmd_t  q_cmd,
  input  logic            q_pop
);
  import dmps_pkg::*;

  cmd_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               push;
  cmd_t               classified;

  // Clamp a signed request to 0..100
  function automatic logic [PWR_W-1:0] clamp_power(input logic [VALUE_W-1:0] v);
    logic [PWR_W-1:0] res;
    if (v[VALUE_W-1]) begin
      res = '0;
    end else if (v > VALUE_W'(FULL_POWER)) begin
      res = FULL_POWER;
    end else begin
      res = v[PWR_W-1:0];
    end
    return res;
  endfunction

  // Classify the incoming function code
  always_comb begin
    classified.power = clamp_power(cmd.value);
    case (cmd.func)
      FN_TICK:      classified.op = OP_TICK;
      FN_SET_BOTH:  classified.op = OP_SET_BOTH;
      FN_START_RMP: classified.op = OP_START_RMP;
      FN_START_SEQ: classified.op = OP_START_SEQ;
      FN_SET_A:     classified.op = OP_SET_A;
      FN_SET_B:     classified.op = OP_SET_B;
      default:      classified.op = OP_NONE;
    endcase
  end

  assign cmd.ready = (count < Q_CNT_W'(Q_DEPTH));
  assign push      = cmd.valid && cmd.ready;
  assign q_valid   = (count != '0);
  assign q_cmd     = entries[rd_ptr];

  // Store classified entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classified;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH))
    else $error("command queue over capacity");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> count != '0)
    else $error("pop from empty command queue");

endmodule

// ----- rtl/core/dmps_back.sv -----
// Back end: configuration registers, motor, ramp and sequence state, result register.
module dmps_back (
  input  logic             clk,
  input  logic             rst,
  input  dmps_pkg::cfg_wr_t cfg,
  input  logic             q_valid,
  input  dmps_pkg::cmd_t   q_cmd,
  output logic             q_pop,
  dmps_res_if.source       res
);
  import dmps_pkg::*;

  // Configuration
  logic [DUR_W-1:0]           ramp_interval;
  logic [DUR_W-1:0]           hold_time;
  logic [SEQ_STEPS*PWR_W-1:0] seq_powers;
  logic [CFG_W-1:0]           seq_times_lo;
  logic [CFG_W-1:0]           seq_times_hi;

  // Working state
  logic [TIME_WIDTH-1:0] time_now,        time_now_next;
  logic [PWR_W-1:0]      motor_a,         motor_a_next;
  logic [PWR_W-1:0]      motor_b,         motor_b_next;
  logic [PHASE_W-1:0]    ramp_state,      ramp_state_next;
  logic [PWR_W-1:0]      ramp_level,      ramp_level_next;
  logic [TIME_WIDTH-1:0] ramp_last,       ramp_last_next;
  logic [TIME_WIDTH-1:0] hold_start,      hold_start_next;
  logic                  seq_active,      seq_active_next;
  logic [STEP_W-1:0]     seq_index,       seq_index_next;
  logic [TIME_WIDTH-1:0] seq_last,        seq_last_next;

  logic                  res_valid;
  logic [TIME_WIDTH-1:0] tick_time;
  logic [STEP_W-1:0]     seq_index_inc;

  // Saturated table power of one step
  function automatic logic [PWR_W-1:0] table_power(input logic [SEQ_STEPS*PWR_W-1:0] tbl,
                                                   input logic [STEP_W-1:0] step);
    logic [PWR_W-1:0] p;
    p = tbl[32'(step) * PWR_W +: PWR_W];
    return (p > FULL_POWER) ? FULL_POWER : p;
  endfunction

  // Duration of one step
  function automatic logic [DUR_W-1:0] table_time(input logic [CFG_W-1:0] lo,
                                                  input logic [CFG_W-1:0] hi,
                                                  input logic [STEP_W-1:0] step);
    logic [CFG_W-1:0] word;
    word = step[2] ? hi : lo;
    return word[32'(step[1:0]) * DUR_W +: DUR_W];
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_interval <= RAMP_INTERVAL_RST;
      hold_time     <= HOLD_TIME_RST;
      seq_powers    <= '0;
      seq_times_lo  <= '0;
      seq_times_hi  <= '0;
    end else if (cfg.en) begin
      case (cfg.index)
        REG_RAMP_INTERVAL: ramp_interval <= cfg.data[DUR_W-1:0];
        REG_HOLD_TIME:     hold_time     <= cfg.data[DUR_W-1:0];
        REG_SEQ_POWERS:    seq_powers    <= cfg.data[SEQ_STEPS*PWR_W-1:0];
        REG_SEQ_TIMES_LO:  seq_times_lo  <= cfg.data;
        REG_SEQ_TIMES_HI:  seq_times_hi  <= cfg.data;
        default:           ;
      endcase
    end
  end

  // Take the next queued command whenever the result slot frees up
  assign q_pop         = q_valid && (!res_valid || res.ready);
  assign tick_time     = time_now + 1'b1;
  assign seq_index_inc = seq_index + 1'b1;

  // Execute one command
  always_comb begin
    time_now_next   = time_now;
    motor_a_next    = motor_a;
    motor_b_next    = motor_b;
    ramp_state_next = ramp_state;
    ramp_level_next = ramp_level;
    ramp_last_next  = ramp_last;
    hold_start_next = hold_start;
    seq_active_next = seq_active;
    seq_index_next  = seq_index;
    seq_last_next   = seq_last;
    case (q_cmd.op)
      OP_TICK: begin
        time_now_next = tick_time;
        // Ramp first
        if (ramp_state != PH_IDLE &&
            (tick_time - ramp_last) > TIME_WIDTH'(ramp_interval)) begin
          ramp_last_next = tick_time;
          case (ramp_state)
            PH_UP: begin
              if (ramp_level + 1'b1 >= FULL_POWER) begin
                ramp_level_next = FULL_POWER;
                ramp_state_next = PH_HOLD;
                hold_start_next = tick_time;
              end else begin
                ramp_level_next = ramp_level + 1'b1;
              end
            end
            PH_HOLD: begin
              if ((tick_time - hold_start) > TIME_WIDTH'(hold_time)) begin
                ramp_state_next = PH_DOWN;
              end
            end
            default: begin
              if (ramp_level <= PWR_W'(1)) begin
                ramp_level_next = '0;
                ramp_state_next = PH_IDLE;
              end else begin
                ramp_level_next = ramp_level - 1'b1;
              end
            end
          endcase
          motor_a_next = ramp_level_next;
          motor_b_next = ramp_level_next;
        end
        // Sequence second, overriding the drive
        if (seq_active && (tick_time - seq_last) >
            TIME_WIDTH'(table_time(seq_times_lo, seq_times_hi, seq_index))) begin
          seq_index_next = seq_index_inc;
          if (seq_index_inc >= STEP_W'(SEQ_STEPS)) begin
            seq_active_next = 1'b0;
            motor_a_next    = '0;
            motor_b_next    = '0;
          end else begin
            motor_a_next  = table_power(seq_powers, seq_index_inc);
            motor_b_next  = table_power(seq_powers, seq_index_inc);
            seq_last_next = tick_time;
          end
        end
      end
      OP_SET_BOTH: begin
        ramp_state_next = PH_IDLE;
        seq_active_next = 1'b0;
        motor_a_next    = q_cmd.power;
        motor_b_next    = q_cmd.power;
      end
      OP_START_RMP: begin
        ramp_level_next = motor_a;
        ramp_state_next = PH_UP;
        ramp_last_next  = time_now;
        seq_active_next = 1'b0;
      end
      OP_START_SEQ: begin
        seq_index_next  = '0;
        seq_last_next   = time_now;
        seq_active_next = 1'b1;
        motor_a_next    = table_power(seq_powers, '0);
        motor_b_next    = table_power(seq_powers, '0);
      end
      OP_SET_A: motor_a_next = q_cmd.power;
      OP_SET_B: motor_b_next = q_cmd.power;
      default:  ;
    endcase
  end

  // Commit state on each executed command
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now   <= '0;
      motor_a    <= '0;
      motor_b    <= '0;
      ramp_state <= PH_IDLE;
      ramp_level <= '0;
      ramp_last  <= '0;
      hold_start <= '0;
      seq_active <= 1'b0;
      seq_index  <= '0;
      seq_last   <= '0;
    end else if (q_pop) begin
      time_now   <= time_now_next;
      motor_a    <= motor_a_next;
      motor_b    <= motor_b_next;
      ramp_state <= ramp_state_next;
      ramp_level <= ramp_level_next;
      ramp_last  <= ramp_last_next;
      hold_start <= hold_start_next;
      seq_active <= seq_active_next;
      seq_index  <= seq_index_next;
      seq_last   <= seq_last_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (q_pop) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res.drive_a          <= motor_a_next;
      res.drive_b          <= motor_b_next;
      res.ramp_phase       <= ramp_state_next;
      res.sequence_running <= seq_active_next;
      res.sequence_step    <= seq_index_next;
    end
  end

  assign res.valid = res_valid;

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    ramp_level <= FULL_POWER && motor_a <= FULL_POWER && motor_b <= FULL_POWER)
    else $error("power level above full scale");
  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    ramp_state == PH_HOLD |-> ramp_level == FULL_POWER)
    else $error("ramp hold below full power");
  a_seq_index: assert property (@(posedge clk) disable iff (rst)
    seq_active |-> seq_index < STEP_W'(SEQ_STEPS))
    else $error("running sequence past its last step");
  a_result_follows_pop: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> res_valid && res.sequence_running == seq_active)
    else $error("result does not reflect executed command");

endmodule

// ----- rtl/core/dual_motor_power_sequencer_unit.sv -----
// Top level of the dual motor power sequencer.
//
//  channel  dir  handshake        payload
//  cmd      in   valid/ready      func[2:0], value[15:0] signed
//  res      out  valid/ready      drive_a, drive_b, ramp_phase, sequence_running,
//                                 sequence_step
//  config   in   wr_en            wr_index[2:0], wr_data[63:0]
//
// One command per cycle is sustained while results are taken; each passes through
// the queue register, then the result register, before it leaves the block.
// The back end executes one queued command per cycle while its result slot is free:
// one tick's ramp and sequence compares are combinational.
// Reset is synchronous; it restores register defaults and clears the queue pointers, working state and result valid.
// A stalled result holds the back end; the two-entry queue keeps taking
// commands until it fills.
module dual_motor_power_sequencer_unit (
  input  logic                            clk,
  input  logic                            rst,
  dmps_cmd_if.sink                        cmd,
  dmps_res_if.source                      res,
  input  logic                            wr_en,
  input  logic [dmps_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [dmps_pkg::CFG_W-1:0]      wr_data
);
  import dmps_pkg::*;

  logic    q_valid;
  logic    q_pop;
  cmd_t    q_cmd;
  cfg_wr_t cfg;

  assign cfg.en    = wr_en;
  assign cfg.index = wr_index;
  assign cfg.data  = wr_data;

  dmps_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  dmps_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule
